FILE: rtl/lsme_pkg.sv
// ----------------------------------------------------------------------------
// lsme_pkg: shared types and constants of the LSB message extractor
// Beat formats, header layout, status and phase codes.
// ----------------------------------------------------------------------------
package lsme_pkg;

  localparam int unsigned LenDigits   = 4;
  localparam int unsigned HeaderChars = 3 + LenDigits;
  localparam int unsigned PosW        = 3;
  localparam int unsigned LenW        = 14;

  localparam logic [PosW-1:0] HdrLastPos = PosW'(HeaderChars - 1);

  // Phase codes of the back end.
  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhMessage = 2'd1;
  localparam logic [1:0] PhDone    = 2'd2;

  // Result status codes.
  localparam logic [1:0] StChar      = 2'd0;
  localparam logic [1:0] StBadHeader = 2'd1;
  localparam logic [1:0] StEmpty     = 2'd2;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiNine = 8'h39;

  typedef struct packed {
    logic [7:0] cover_byte;
    logic       restart;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [1:0] status;
    logic       last;
  } out_beat_t;

  // One assembled character, flagged when it is the first of a new image.
  typedef struct packed {
    logic [7:0] ch;
    logic       new_image;
  } char_beat_t;

  // Expected tag letter at header positions 0 to 2.
  function automatic logic [7:0] tag_letter(input logic [1:0] pos);
    logic [7:0] res;
    case (pos)
      2'd0:    res = 8'h42;
      2'd1:    res = 8'h4D;
      2'd2:    res = 8'h50;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/lsb_stego_message_extractor.sv
// ----------------------------------------------------------------------------
// lsb_stego_message_extractor: LSB steganography message extractor
// Recovers a length-prefixed message from the low bits of pixel bytes.
// ----------------------------------------------------------------------------
// One pixel byte is accepted every cycle while full is low. Each eighth byte
// completes a character, which passes through a two-entry queue to the decoder;
// the decoder writes each result into a two-entry result queue that feeds the
// output side. Decoder and result queue each handle one beat a cycle, so full
// only rises when the result side has been stalled long enough for both queues
// to fill. There is no clearing pass after reset.
module lsb_stego_message_extractor import lsme_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_beat_t  in_beat_i,
  output logic      empty,
  input  logic      pop,
  output out_beat_t out_beat_o
);

  logic       accept;
  logic       char_push;
  char_beat_t char_wdata;
  char_beat_t char_rdata;
  logic       char_valid;
  logic       char_full;
  logic       char_pop;
  logic       res_valid;

  assign full   = char_full;
  assign accept = push && !char_full;
  assign empty  = !res_valid;

  lsme_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_beat_i   (in_beat_i),
    .char_push_o (char_push),
    .char_beat_o (char_wdata)
  );

  lsme_char_q u_char_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (char_push),
    .wdata_i (char_wdata),
    .pop_i   (char_pop),
    .rdata_o (char_rdata),
    .valid_o (char_valid),
    .full_o  (char_full)
  );

  lsme_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (char_valid),
    .char_beat_i  (char_rdata),
    .char_pop_o   (char_pop),
    .res_pop_i    (pop && res_valid),
    .res_valid_o  (res_valid),
    .res_beat_o   (out_beat_o)
  );

endmodule

FILE: rtl/lsme_front.sv
// ----------------------------------------------------------------------------
// lsme_front: bit collector
// Takes the least significant bit of each cover byte and packs eight of them,
// most significant first, into a character beat for the back end.
// ----------------------------------------------------------------------------
module lsme_front import lsme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  in_beat_t   in_beat_i,
  output logic       char_push_o,
  output char_beat_t char_beat_o
);

  logic [2:0] bit_cnt_q, bit_cnt_d;
  logic [6:0] shift_q, shift_d;
  logic       new_img_q, new_img_d;

  logic [2:0] cnt_eff;
  logic [6:0] shift_eff;
  logic       new_img_eff;

  always_comb begin
    cnt_eff     = in_beat_i.restart ? 3'd0 : bit_cnt_q;
    shift_eff   = in_beat_i.restart ? 7'd0 : shift_q;
    new_img_eff = in_beat_i.restart | new_img_q;

    char_push_o          = accept_i && (cnt_eff == 3'd7);
    char_beat_o.ch       = {shift_eff, in_beat_i.cover_byte[0]};
    char_beat_o.new_image = new_img_eff;

    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    new_img_d = new_img_q;
    if (accept_i) begin
      bit_cnt_d = cnt_eff + 3'd1;
      shift_d   = {shift_eff[5:0], in_beat_i.cover_byte[0]};
      // The restart mark travels with the first character that completes.
      new_img_d = char_push_o ? 1'b0 : new_img_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= 3'd0;
      shift_q   <= 7'd0;
      new_img_q <= 1'b0;
    end else begin
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      new_img_q <= new_img_d;
    end
  end

endmodule

FILE: rtl/lsme_char_q.sv
// ----------------------------------------------------------------------------
// lsme_char_q: two-entry character queue
// Decouples the bit collector from the header and message decoder.
// ----------------------------------------------------------------------------
module lsme_char_q import lsme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  char_beat_t wdata_i,
  input  logic       pop_i,
  output char_beat_t rdata_o,
  output logic       valid_o,
  output logic       full_o
);

  char_beat_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("character queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("character queue read while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("character queue count out of range");

endmodule

FILE: rtl/lsme_back.sv
// ----------------------------------------------------------------------------
// lsme_back: header and message decoder
// Checks the tag, accumulates the decimal length, emits message characters and
// status results into a two-entry result queue.
// ----------------------------------------------------------------------------
module lsme_back import lsme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       char_valid_i,
  input  char_beat_t char_beat_i,
  output logic       char_pop_o,
  input  logic       res_pop_i,
  output logic       res_valid_o,
  output out_beat_t  res_beat_o
);

  logic [1:0]      phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            good_q, good_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] left_q, left_d;

  // Result queue.
  out_beat_t  res_mem_q [2];
  logic       res_wr_q, res_rd_q;
  logic [1:0] res_cnt_q;
  logic       res_full;
  logic       res_push;
  out_beat_t  res_new;

  logic [1:0]      ph_e;
  logic [PosW-1:0] pos_e;
  logic            good_e;
  logic [LenW-1:0] len_e;
  logic [LenW-1:0] left_e;
  logic [7:0]      ch;
  logic            is_digit;
  logic [LenW-1:0] len_next;
  logic [LenW-1:0] left_next;

  assign res_full    = (res_cnt_q == 2'd2);
  assign res_valid_o = (res_cnt_q != 2'd0);
  assign res_beat_o  = res_mem_q[res_rd_q];
  assign char_pop_o  = char_valid_i && !res_full;

  always_comb begin
    ch = char_beat_i.ch;
    if (char_beat_i.new_image) begin
      ph_e   = PhHeader;
      pos_e  = '0;
      good_e = 1'b1;
      len_e  = '0;
      left_e = '0;
    end else begin
      ph_e   = phase_q;
      pos_e  = pos_q;
      good_e = good_q;
      len_e  = len_q;
      left_e = left_q;
    end

    is_digit  = (ch >= AsciiZero) && (ch <= AsciiNine);
    len_next  = (len_e << 3) + (len_e << 1) + LenW'(ch - AsciiZero);
    left_next = left_e - LenW'(1);

    phase_d  = phase_q;
    pos_d    = pos_q;
    good_d   = good_q;
    len_d    = len_q;
    left_d   = left_q;
    res_push = 1'b0;
    res_new  = '0;

    if (char_pop_o) begin
      phase_d = ph_e;
      pos_d   = pos_e;
      good_d  = good_e;
      len_d   = len_e;
      left_d  = left_e;
      case (ph_e)
        PhHeader: begin
          if (pos_e < PosW'(3)) begin
            if (ch != tag_letter(pos_e[1:0])) begin
              good_d = 1'b0;
            end
          end else if (is_digit) begin
            len_d = len_next;
          end else begin
            good_d = 1'b0;
          end
          pos_d = pos_e + PosW'(1);
          if (pos_e == HdrLastPos) begin
            if (!good_d) begin
              phase_d        = PhDone;
              res_push       = 1'b1;
              res_new.status = StBadHeader;
              res_new.last   = 1'b1;
            end else if (len_d == '0) begin
              phase_d        = PhDone;
              res_push       = 1'b1;
              res_new.status = StEmpty;
              res_new.last   = 1'b1;
            end else begin
              left_d  = len_d;
              phase_d = PhMessage;
            end
          end
        end
        PhMessage: begin
          left_d           = left_next;
          res_push         = 1'b1;
          res_new.char_out = ch;
          res_new.status   = StChar;
          res_new.last     = (left_next == '0);
          if (left_next == '0) begin
            phase_d = PhDone;
          end
        end
        default: begin
          // Done, or the unused code: characters are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      pos_q   <= '0;
      good_q  <= 1'b1;
      len_q   <= '0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      good_q  <= good_d;
      len_q   <= len_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr_q <= ~res_wr_q;
      end
      if (res_pop_i) begin
        res_rd_q <= ~res_rd_q;
      end
      res_cnt_q <= res_cnt_q + {1'b0, res_push} - {1'b0, res_pop_i};
    end
  end

  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result queue written while full");

  a_status_has_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_new.status != StChar) |-> (res_new.last && res_new.char_out == 8'h00))
    else $error("status result must be last and carry no character");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_new.last) |=> (phase_q == PhDone))
    else $error("decoder not done after final result");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: LSB steganography message extractor
// Streams pixel bytes that carry images (good headers, damaged headers, empty
// and cut-short messages, restarts and noise) into the block. A predictor
// tracks the decoder and the results are checked beat by beat, in order.
// ----------------------------------------------------------------------------
module testbench;
  import lsme_pkg::*;

  localparam int CycleLimit  = 250000;
  localparam int RandomItems = 1500;
  localparam int TailBeats   = 250;
  localparam int DrainCycles = 16;
  localparam int LongHold    = 400;
  localparam int FillRandom  = 0;
  localparam int FillZeros   = 1;
  localparam int FillOnes    = 2;

  localparam logic [7:0] TagChars [3] = '{8'h42, 8'h4D, 8'h50};

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push   = 1'b0;
  logic      pop    = 1'b0;
  in_beat_t  in_beat_i = '0;
  logic      full;
  logic      empty;
  out_beat_t out_beat_o;

  in_beat_t  pixel_beats[$];
  in_beat_t  image_beats[$];
  out_beat_t expected_chars[$];

  // Decoder state as the predictor sees it.
  logic [2:0]  bit_cnt;
  logic [7:0]  shreg;
  logic [1:0]  ph;
  logic [2:0]  hpos;
  logic        hgood;
  logic [13:0] len_acc;
  logic [13:0] remaining;

  int cycle_count    = 0;
  int mismatches     = 0;
  int results_seen   = 0;
  int image_items    = 0;
  int send_gap       = 0;
  int recv_gap       = 0;
  int hold_left      = 0;
  bit long_hold_done = 1'b0;
  bit idle_ok        = 1'b0;

  lsb_stego_message_extractor uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_beat_i  (in_beat_i),
    .empty      (empty),
    .pop        (pop),
    .out_beat_o (out_beat_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void clear_decoder();
    bit_cnt   = '0;
    shreg     = '0;
    ph        = PhHeader;
    hpos      = '0;
    hgood     = 1'b1;
    len_acc   = '0;
    remaining = '0;
  endfunction

  function automatic void decode_beat(input in_beat_t b);
    logic [7:0] c;
    if (b.restart) clear_decoder();
    if (ph != PhHeader && ph != PhMessage) return;
    c = {shreg[6:0], b.cover_byte[0]};
    if (bit_cnt != 3'd7) begin
      shreg   = c;
      bit_cnt = bit_cnt + 3'd1;
      return;
    end
    bit_cnt = '0;
    shreg   = '0;
    if (ph == PhHeader) begin
      if (hpos < 3) begin
        if (c != TagChars[hpos]) hgood = 1'b0;
      end else if (c >= AsciiZero && c <= AsciiNine) begin
        len_acc = len_acc * 10 + (c - AsciiZero);
      end else begin
        hgood = 1'b0;
      end
      hpos = hpos + 3'd1;
      if (hpos == HeaderChars) begin
        if (!hgood) begin
          ph = PhDone;
          expected_chars.push_back('{char_out: 8'h00, status: StBadHeader, last: 1'b1});
        end else if (len_acc == '0) begin
          ph = PhDone;
          expected_chars.push_back('{char_out: 8'h00, status: StEmpty, last: 1'b1});
        end else begin
          remaining = len_acc;
          ph        = PhMessage;
        end
      end
    end else begin
      remaining = remaining - 14'd1;
      if (remaining == '0) ph = PhDone;
      expected_chars.push_back('{char_out: c, status: StChar, last: remaining == '0});
    end
  endfunction

  // Each character goes out as eight bytes, MSB first in the low bits.
  task automatic put_char(input logic [7:0] c, input int fill);
    in_beat_t b;
    for (int i = 7; i >= 0; i--) begin
      case (fill)
        FillZeros: b.cover_byte = {7'h00, c[i]};
        FillOnes:  b.cover_byte = {7'h7F, c[i]};
        default:   b.cover_byte = {7'($urandom), c[i]};
      endcase
      b.restart = 1'b0;
      image_beats.push_back(b);
    end
  endtask

  task automatic put_header(input logic [55:0] hdr, input int fill);
    for (int k = 6; k >= 0; k--) put_char(hdr[k*8 +: 8], fill);
  endtask

  // Moves the image built so far to the stimulus, optionally cut short.
  task automatic flush_image(input bit rst, input int cut);
    int n;
    n = (cut > 0 && cut < image_beats.size()) ? cut : image_beats.size();
    if (rst && n > 0) image_beats[0].restart = 1'b1;
    for (int i = 0; i < n; i++) pixel_beats.push_back(image_beats[i]);
    image_items += n;
    image_beats.delete();
  endtask

  task automatic queue_image(input logic [55:0] hdr, input int n_msg, input bit rst,
                             input int cut, input int fill);
    put_header(hdr, fill);
    for (int i = 0; i < n_msg; i++)
      put_char(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom), fill);
    flush_image(rst, cut);
  endtask

  task automatic queue_noise(input int n, input bit mix_restart);
    in_beat_t b;
    for (int i = 0; i < n; i++) begin
      b.cover_byte = 8'($urandom);
      b.restart    = mix_restart && ($urandom_range(0, 3) == 0);
      pixel_beats.push_back(b);
    end
  endtask

  function automatic logic [55:0] header_for(input int len);
    return {"BMP", AsciiZero + 8'(len / 1000 % 10), AsciiZero + 8'(len / 100 % 10),
            AsciiZero + 8'(len / 10 % 10), AsciiZero + 8'(len % 10)};
  endfunction

  task automatic report_mismatch(input string what, input out_beat_t want,
                                 input out_beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%s at cycle %0d: expected char %h status %0d last %0d, ",
                "got char %h status %0d last %0d"},
               what, cycle_count, want.char_out, want.status, want.last,
               got.char_out, got.status, got.last);
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    results_seen++;
    if (expected_chars.size() == 0) begin
      report_mismatch("unexpected result", '0, got);
      return;
    end
    want = expected_chars.pop_front();
    if (got.char_out !== want.char_out || got.status !== want.status ||
        got.last !== want.last)
      report_mismatch("wrong result", want, got);
  endtask

  // Driver: holds a beat until it is taken, then idles now and again.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      in_beat_i <= '0;
      send_gap  <= 0;
      idle_ok   <= 1'b0;
    end else begin
      idle_ok <= (pixel_beats.size() > TailBeats) && (cycle_count[9:8] != 2'b00);
      if (push && !full) decode_beat(in_beat_i);
      if (!push || !full) begin
        if (send_gap > 0 && hold_left == 0) begin
          send_gap <= send_gap - 1;
          push     <= 1'b0;
        end else if (pixel_beats.size() != 0) begin
          in_beat_i <= pixel_beats.pop_front();
          push      <= 1'b1;
          if (idle_ok && hold_left == 0 && $urandom_range(0, 7) == 0)
            send_gap <= $urandom_range(1, 17);
          else
            send_gap <= 0;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every beat taken and stalls the result side at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop       <= 1'b0;
      recv_gap  <= 0;
      hold_left <= 0;
    end else begin
      if (pop && !empty) check_result(out_beat_o);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else if (!long_hold_done && results_seen >= 60) begin
        // One long stall so that both internal queues fill and full rises.
        hold_left      <= LongHold;
        long_hold_done <= 1'b1;
        pop            <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        pop      <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 16);
        pop      <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    logic [55:0] hdr;
    int          mode;
    int          len;
    int          sel;
    int          pos;
    logic [7:0]  val;

    clear_decoder();

    // Directed images. The first one relies on the reset state alone.
    put_header("BMP0003", FillZeros);
    put_char(8'h00, FillOnes);
    put_char(8'hFF, FillZeros);
    put_char(8'h7E, FillOnes);
    flush_image(1'b0, 0);
    queue_noise(9, 1'b0);
    queue_image("BMP0000", 0, 1'b1, 0, FillOnes);
    queue_image("XMP0002", 2, 1'b1, 0, FillRandom);
    queue_image("BMX0001", 1, 1'b1, 0, FillRandom);
    queue_image("BMP00A1", 1, 1'b1, 0, FillRandom);
    queue_image("BMP/000", 0, 1'b1, 0, FillRandom);
    queue_image("BMP000:", 0, 1'b1, 0, FillRandom);
    queue_image("BMP9999", 3, 1'b1, 0, FillRandom);
    queue_image("BMP0001", 1, 1'b1, 0, FillRandom);
    queue_image("BMP0009", 9, 1'b1, 20, FillRandom);
    queue_image("BMP0012", 12, 1'b1, 0, FillRandom);

    // Random images, mostly well formed, with damaged and cut-short ones mixed in.
    while (image_items < RandomItems) begin
      mode = $urandom_range(0, 99);
      sel  = $urandom_range(0, 19);
      if (sel < 3)       len = 0;
      else if (sel < 15) len = $urandom_range(1, 6);
      else if (sel < 19) len = $urandom_range(7, 20);
      else               len = $urandom_range(21, 60);
      hdr = header_for(len);
      if (mode < 68) begin
        queue_image(hdr, len, $urandom_range(0, 15) != 0, 0, FillRandom);
        if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(1, 12), 1'b0);
      end else if (mode < 80) begin
        pos = $urandom_range(0, 6);
        case ($urandom_range(0, 3))
          0:       val = AsciiZero - 8'd1;
          1:       val = AsciiNine + 8'd1;
          2:       val = 8'($urandom);
          default: val = hdr[(6-pos)*8 +: 8] ^ (8'd1 << $urandom_range(0, 7));
        endcase
        hdr[(6-pos)*8 +: 8] = val;
        queue_image(hdr, len, 1'b1, 0, FillRandom);
      end else if (mode < 92) begin
        len = $urandom_range(0, 9999);
        queue_image(header_for(len), (len < 12) ? len : 12, 1'b1,
                    $urandom_range(1, 150), FillRandom);
      end else begin
        queue_noise($urandom_range(1, 24), 1'b1);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_beats.size() != 0 || push) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lsme_pkg.sv
rtl/lsme_front.sv
rtl/lsme_char_q.sv
rtl/lsme_back.sv
rtl/lsb_stego_message_extractor.sv
dv/testbench.sv
